// File: rtl/bus_frame_deframer_core_defines.svh
// Assertion macros shared by the deframer modules.
`ifndef BUS_FRAME_DEFRAMER_CORE_DEFINES_SVH
`define BUS_FRAME_DEFRAMER_CORE_DEFINES_SVH

// Check a condition at every clock edge outside reset.
`define BFD_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// Check that a consequent holds in the same cycle as its antecedent.
`define BFD_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// File: rtl/bfd_pkg.sv
package bfd_pkg;

    // Frame geometry
    localparam int MAX_DATA   = 15;
    localparam int HDR_LEN    = 4;              // start, priority, address, length
    localparam int HDR_TRL    = 6;              // header plus checksum and end
    localparam int WIN_DEPTH  = HDR_TRL + MAX_DATA;
    localparam int FILL_W     = $clog2(WIN_DEPTH + 1);
    localparam int IDX_W      = $clog2(WIN_DEPTH);
    localparam int LEN_W      = 4;
    localparam int DIDX_W     = (MAX_DATA > 1) ? $clog2(MAX_DATA) : 1;

    // Queue between parser and emitter
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Byte codes
    localparam logic [7:0] START_BYTE = 8'h0F;
    localparam logic [7:0] PRIO_MASK  = 8'hFC;
    localparam logic [7:0] PRIO_TAG   = 8'hF8;
    localparam logic [7:0] LEN_MASK   = 8'hB0;
    localparam logic [7:0] END_BYTE   = 8'h04;

    typedef enum logic [2:0] {
        FS_IDLE,
        FS_CHECK,
        FS_SCAN,
        FS_PUSH,
        FS_DROP
    } t_front_state;

    typedef struct packed {
        logic [1:0]                  prio;
        logic [7:0]                  addr;
        logic                        rtr;
        logic [LEN_W-1:0]            len;
        logic [MAX_DATA-1:0][7:0]    data;
    } t_frame;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

// File: rtl/bfd_front.sv
`include "bus_frame_deframer_core_defines.svh"

module bfd_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [7:0]       i_rx_byte,
    input  bfd_pkg::t_q_stat i_q_stat,
    output logic             o_push,
    output bfd_pkg::t_frame  o_frame
);
    import bfd_pkg::*;

    t_front_state     r_state, n_state;
    logic [7:0]       r_win [WIN_DEPTH];
    logic [FILL_W-1:0] r_fill, n_fill;
    logic [FILL_W-1:0] r_cnt, n_cnt;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [7:0]       r_sum, n_sum;
    logic [LEN_W-1:0] r_len, n_len;
    t_frame           r_frame, n_frame;

    logic             w_shift;
    logic             w_wr;
    logic [IDX_W-1:0] w_wr_idx;
    logic             w_full;
    logic             w_short;
    logic             w_hdr_bad;
    logic [LEN_W-1:0] w_hdr_len;
    logic [FILL_W-1:0] w_need;
    logic [FILL_W-1:0] w_need_scan;
    logic [IDX_W-1:0] w_chk_pos;
    logic [IDX_W-1:0] w_didx;
    logic [7:0]       w_rd;
    logic             w_sum_bad;
    logic             w_end_bad;

    // Decode the window head and the scan position
    assign w_full      = (r_fill == FILL_W'(WIN_DEPTH));
    assign w_short     = (r_fill < FILL_W'(HDR_TRL));
    assign w_hdr_len   = r_win[3][LEN_W-1:0];
    assign w_hdr_bad   = (r_win[0] != START_BYTE)
                      || ((r_win[1] & PRIO_MASK) != PRIO_TAG)
                      || ((r_win[3] & LEN_MASK) != 8'h00)
                      || (int'(w_hdr_len) > MAX_DATA);
    assign w_need      = FILL_W'(HDR_TRL) + FILL_W'(w_hdr_len);
    assign w_need_scan = FILL_W'(HDR_TRL) + FILL_W'(r_len);
    assign w_chk_pos   = IDX_W'(HDR_LEN) + IDX_W'(r_len);
    assign w_didx      = r_idx - IDX_W'(HDR_LEN);
    assign w_rd        = r_win[r_idx];
    assign w_sum_bad   = (w_rd != (8'h00 - r_sum));
    assign w_end_bad   = (w_rd != END_BYTE);
    assign o_frame     = r_frame;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            FS_IDLE: begin
                if (i_valid) n_state = FS_CHECK;
            end
            FS_CHECK: begin
                if (w_short) begin
                    n_state = FS_IDLE;
                end else if (w_hdr_bad) begin
                    n_state = FS_CHECK;
                end else if (r_fill < w_need) begin
                    n_state = FS_IDLE;
                end else begin
                    n_state = FS_SCAN;
                end
            end
            FS_SCAN: begin
                if (r_idx == w_chk_pos) begin
                    if (w_sum_bad) n_state = FS_CHECK;
                end else if (r_idx > w_chk_pos) begin
                    n_state = w_end_bad ? FS_CHECK : FS_PUSH;
                end
            end
            FS_PUSH: begin
                if (!i_q_stat.full) n_state = FS_DROP;
            end
            FS_DROP: begin
                if (r_cnt == FILL_W'(1)) n_state = FS_IDLE;
            end
            default: n_state = FS_IDLE;
        endcase
    end

    // Datapath controls per state
    always_comb begin
        w_shift  = 1'b0;
        w_wr     = 1'b0;
        w_wr_idx = r_fill[IDX_W-1:0];
        o_push   = 1'b0;
        o_ready  = 1'b0;
        n_fill   = r_fill;
        n_cnt    = r_cnt;
        n_idx    = r_idx;
        n_sum    = r_sum;
        n_len    = r_len;
        n_frame  = r_frame;
        unique case (r_state)
            FS_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    w_wr = 1'b1;
                    // A full window loses its oldest byte
                    if (w_full) begin
                        w_shift  = 1'b1;
                        w_wr_idx = IDX_W'(WIN_DEPTH - 1);
                    end else begin
                        n_fill = r_fill + FILL_W'(1);
                    end
                end
            end
            FS_CHECK: begin
                if (!w_short) begin
                    if (w_hdr_bad) begin
                        w_shift = 1'b1;
                        n_fill  = r_fill - FILL_W'(1);
                    end else if (r_fill >= w_need) begin
                        n_idx        = '0;
                        n_sum        = 8'h00;
                        n_len        = w_hdr_len;
                        n_frame.prio = r_win[1][1:0];
                        n_frame.addr = r_win[2];
                        n_frame.rtr  = r_win[3][6];
                        n_frame.len  = w_hdr_len;
                    end
                end
            end
            FS_SCAN: begin
                if (r_idx < w_chk_pos) begin
                    // Accumulate the checksum and capture data bytes
                    n_sum = r_sum + w_rd;
                    if (r_idx >= IDX_W'(HDR_LEN)) n_frame.data[w_didx[DIDX_W-1:0]] = w_rd;
                    n_idx = r_idx + IDX_W'(1);
                end else if (r_idx == w_chk_pos) begin
                    if (w_sum_bad) begin
                        w_shift = 1'b1;
                        n_fill  = r_fill - FILL_W'(1);
                    end else begin
                        n_idx = r_idx + IDX_W'(1);
                    end
                end else if (w_end_bad) begin
                    w_shift = 1'b1;
                    n_fill  = r_fill - FILL_W'(1);
                end
            end
            FS_PUSH: begin
                if (!i_q_stat.full) begin
                    o_push = 1'b1;
                    n_cnt  = w_need_scan;
                end
            end
            FS_DROP: begin
                w_shift = 1'b1;
                n_fill  = r_fill - FILL_W'(1);
                n_cnt   = r_cnt - FILL_W'(1);
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FS_IDLE;
            r_fill  <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_cnt   <= n_cnt;
        end
    end

    // Scan registers and frame staging
    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_sum   <= n_sum;
        r_len   <= n_len;
        r_frame <= n_frame;
    end

    // Window: shift toward the head, append at the tail
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < WIN_DEPTH - 1; k++) begin
            if (w_shift) r_win[k] <= r_win[k + 1];
        end
        if (w_wr) r_win[w_wr_idx] <= i_rx_byte;
    end

    `BFD_ASSERT_ALWAYS(a_fill_range, r_fill <= FILL_W'(WIN_DEPTH), "window fill out of range")
    `BFD_ASSERT_IMPL(a_scan_fill, r_state == FS_SCAN, r_fill >= w_need_scan, "scan past fill")
    `BFD_ASSERT_IMPL(a_drop_cnt, r_state == FS_DROP, (r_cnt != '0) && (r_cnt <= r_fill), "bad drop count")

endmodule

// File: rtl/bfd_fifo.sv
`include "bus_frame_deframer_core_defines.svh"

module bfd_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  bfd_pkg::t_frame   i_frame,
    input  logic              i_pop,
    output bfd_pkg::t_frame   o_head,
    output bfd_pkg::t_q_stat  o_stat
);
    import bfd_pkg::*;

    t_frame            r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wp, n_wp;
    logic [QPTR_W-1:0] r_rp, n_rp;
    logic [QCNT_W-1:0] r_count, n_count;

    assign o_head       = r_mem[r_rp];
    assign o_stat.full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_stat.empty = (r_count == '0);

    // Advance pointers with wrap
    always_comb begin
        n_wp    = r_wp;
        n_rp    = r_rp;
        n_count = r_count;
        if (i_push) begin
            n_wp = (r_wp == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wp + QPTR_W'(1);
        end
        if (i_pop) begin
            n_rp = (r_rp == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rp + QPTR_W'(1);
        end
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + QCNT_W'(1);
            2'b01:   n_count = r_count - QCNT_W'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

    // Store a frame record
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_frame;
    end

    `BFD_ASSERT_IMPL(a_no_overflow, i_push, !o_stat.full, "push into full queue")
    `BFD_ASSERT_IMPL(a_no_underflow, i_pop, !o_stat.empty, "pop from empty queue")

endmodule

// File: rtl/bfd_back.sv
`include "bus_frame_deframer_core_defines.svh"

module bfd_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  bfd_pkg::t_frame  i_head,
    input  bfd_pkg::t_q_stat i_q_stat,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [1:0]       o_priority_res,
    output logic [7:0]       o_address,
    output logic             o_remote_request,
    output logic [3:0]       o_data_length,
    output logic             o_has_data,
    output logic [7:0]       o_data_byte,
    output logic [3:0]       o_byte_index,
    output logic             o_last
);
    import bfd_pkg::*;

    logic             r_valid;
    logic [LEN_W-1:0] r_idx, n_idx;
    logic             w_load;
    logic             w_empty_frame;
    logic             w_last;

    assign w_empty_frame = (i_head.len == '0);
    assign w_last        = w_empty_frame || ((r_idx + LEN_W'(1)) == i_head.len);
    assign w_load        = !i_q_stat.empty && (!r_valid || i_ready);
    assign o_pop         = w_load && w_last;
    assign o_valid       = r_valid;

    // Step through the data bytes of the head frame
    always_comb begin
        n_idx = r_idx;
        if (w_load) n_idx = w_last ? '0 : r_idx + LEN_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            r_idx <= n_idx;
            if (w_load) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Load the output register
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            o_priority_res   <= i_head.prio;
            o_address        <= i_head.addr;
            o_remote_request <= i_head.rtr;
            o_data_length    <= i_head.len;
            o_has_data       <= !w_empty_frame;
            o_data_byte      <= w_empty_frame ? 8'h00 : i_head.data[r_idx[DIDX_W-1:0]];
            o_byte_index     <= r_idx;
            o_last           <= w_last;
        end
    end

    `BFD_ASSERT_IMPL(a_idx_in_frame, !i_q_stat.empty && !w_empty_frame, r_idx < i_head.len, "byte index past length")

endmodule

// File: rtl/bus_frame_deframer_core.sv
// Checksummed frame deframer. Received bytes are taken one per transaction into
// a 21-byte window and the window is parsed from its head: start 0x0F, priority
// byte 0xF8|prio, address, length/rtr byte, 0 to 15 data bytes, two's-complement
// checksum and end 0x04. Bytes that cannot start a valid frame are dropped one at
// a time; a good frame is removed and reported as one result per data byte (or a
// single result for an empty frame). After a byte is taken the parser runs
// before ready returns: a header check per attempt, the checksum scan over the
// header and data bytes, and for a good frame its push and byte-by-byte removal.
// Each discarded byte adds a shift and a fresh header check, plus a wasted scan
// when the checksum or end byte is wrong. The window shifts one byte at a time.
// Results leave through a two-frame queue at one per cycle while the receiver
// is ready, independent of the parser; while the queue is full a good frame
// waits in the parser and the input stays stalled.
module bus_frame_deframer_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_rx_byte,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [1:0] o_priority_res,
    output logic [7:0] o_address,
    output logic       o_remote_request,
    output logic [3:0] o_data_length,
    output logic       o_has_data,
    output logic [7:0] o_data_byte,
    output logic [3:0] o_byte_index,
    output logic       o_last
);
    import bfd_pkg::*;

    logic    w_push;
    logic    w_pop;
    t_frame  w_in_frame;
    t_frame  w_head;
    t_q_stat w_q_stat;

    // Window, parser and frame staging
    bfd_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_rx_byte (i_rx_byte),
        .i_q_stat  (w_q_stat),
        .o_push    (w_push),
        .o_frame   (w_in_frame)
    );

    // Queue of accepted frames
    bfd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_frame (w_in_frame),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_stat  (w_q_stat)
    );

    // Result emitter
    bfd_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_head           (w_head),
        .i_q_stat         (w_q_stat),
        .o_pop            (w_pop),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_priority_res   (o_priority_res),
        .o_address        (o_address),
        .o_remote_request (o_remote_request),
        .o_data_length    (o_data_length),
        .o_has_data       (o_has_data),
        .o_data_byte      (o_data_byte),
        .o_byte_index     (o_byte_index),
        .o_last           (o_last)
    );

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;
    import bfd_pkg::*;

    // One result of the deframer, in port order
    typedef struct packed {
        logic [1:0] prio;
        logic [7:0] addr;
        logic       rtr;
        logic [3:0] len;
        logic       has_data;
        logic [7:0] data;
        logic [3:0] idx;
        logic       last;
    } t_res;

    // One row of the directed table: a byte, plus a hand-typed result where obvious
    typedef struct packed {
        logic [7:0] rx;
        logic       typed;
        t_res       want;
    } t_row;

    typedef enum {SCAN_WAIT, SCAN_BAD, SCAN_GOOD} t_scan;

    localparam t_res NO_RES = '0;
    localparam int   HOLD_CYCLES = 1500;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_ready;
    logic [7:0] i_rx_byte = 8'h00;
    logic       o_valid;
    logic       i_ready = 1'b0;
    logic [1:0] o_priority_res;
    logic [7:0] o_address;
    logic       o_remote_request;
    logic [3:0] o_data_length;
    logic       o_has_data;
    logic [7:0] o_data_byte;
    logic [3:0] o_byte_index;
    logic       o_last;

    // Predictor state and the store of expected frame results
    logic [7:0] win_q [$];
    t_res       frame_res [$];
    t_res       pending_res [$];
    logic [7:0] burst_q [$];
    t_res       want_res;

    int n_err = 0;
    int n_rx = 0;
    int hold_left = 0;
    bit hold_go = 1'b0;
    bit calm = 1'b0;

    // Directed bytes: clean empty frame at the extremes, one-byte frame, bad checksum,
    // reserved length bits set, and a stray byte
    t_row dir_rows [24] = '{
        '{8'h0F, 1'b0, NO_RES},
        '{8'hFB, 1'b0, NO_RES},
        '{8'hFF, 1'b0, NO_RES},
        '{8'h40, 1'b0, NO_RES},
        '{8'hB7, 1'b0, NO_RES},
        '{8'h04, 1'b1, '{2'd3, 8'hFF, 1'b1, 4'd0, 1'b0, 8'h00, 4'd0, 1'b1}},
        '{8'h0F, 1'b0, NO_RES},
        '{8'hF8, 1'b0, NO_RES},
        '{8'h00, 1'b0, NO_RES},
        '{8'h01, 1'b0, NO_RES},
        '{8'hFF, 1'b0, NO_RES},
        '{8'hF9, 1'b0, NO_RES},
        '{8'h04, 1'b1, '{2'd0, 8'h00, 1'b0, 4'd1, 1'b1, 8'hFF, 4'd0, 1'b1}},
        '{8'h0F, 1'b0, NO_RES},
        '{8'hF9, 1'b0, NO_RES},
        '{8'h12, 1'b0, NO_RES},
        '{8'h00, 1'b0, NO_RES},
        '{8'h00, 1'b0, NO_RES},
        '{8'h04, 1'b0, NO_RES},
        '{8'h0F, 1'b0, NO_RES},
        '{8'hF8, 1'b0, NO_RES},
        '{8'h00, 1'b0, NO_RES},
        '{8'h30, 1'b0, NO_RES},
        '{8'h5A, 1'b0, NO_RES}
    };

    bus_frame_deframer_core i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_rx_byte        (i_rx_byte),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_priority_res   (o_priority_res),
        .o_address        (o_address),
        .o_remote_request (o_remote_request),
        .o_data_length    (o_data_length),
        .o_has_data       (o_has_data),
        .o_data_byte      (o_data_byte),
        .o_byte_index     (o_byte_index),
        .o_last           (o_last)
    );

    always #5 i_clk = ~i_clk;

    // Print one line per mismatch and count it
    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        n_err++;
    endtask

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    // Judge the window from its head
    function automatic t_scan scan_window(output int unsigned flen);
        logic [7:0] sum;
        flen = 0;
        if (win_q.size() < HDR_TRL) return SCAN_WAIT;
        if (win_q[0] != START_BYTE) return SCAN_BAD;
        if ((win_q[1] & PRIO_MASK) != PRIO_TAG) return SCAN_BAD;
        if ((win_q[3] & LEN_MASK) != 8'h00) return SCAN_BAD;
        flen = win_q[3][3:0];
        if (flen > MAX_DATA) return SCAN_BAD;
        if (win_q.size() < HDR_TRL + flen) return SCAN_WAIT;
        sum = 8'h00;
        for (int i = 0; i < HDR_LEN + flen; i++) sum = sum + win_q[i];
        if (win_q[HDR_LEN + flen] != 8'h00 - sum) return SCAN_BAD;
        if (win_q[HDR_LEN + flen + 1] != END_BYTE) return SCAN_BAD;
        return SCAN_GOOD;
    endfunction

    // Append one byte, resync past bad heads, and emit a good frame into frame_res
    function automatic void deframe_byte(input logic [7:0] rx);
        t_scan       verdict;
        int unsigned flen;
        t_res        r;
        frame_res.delete();
        if (win_q.size() >= WIN_DEPTH) void'(win_q.pop_front());
        win_q.push_back(rx);
        verdict = scan_window(flen);
        while (verdict == SCAN_BAD) begin
            void'(win_q.pop_front());
            verdict = scan_window(flen);
        end
        if (verdict != SCAN_GOOD) return;
        r.prio = win_q[1][1:0];
        r.addr = win_q[2];
        r.rtr  = win_q[3][6];
        r.len  = 4'(flen);
        if (flen == 0) begin
            r.has_data = 1'b0;
            r.data     = 8'h00;
            r.idx      = 4'd0;
            r.last     = 1'b1;
            frame_res.push_back(r);
        end else begin
            for (int i = 0; i < flen; i++) begin
                r.has_data = 1'b1;
                r.data     = win_q[HDR_LEN + i];
                r.idx      = 4'(i);
                r.last     = (i + 1 == flen);
                frame_res.push_back(r);
            end
        end
        repeat (HDR_TRL + flen) void'(win_q.pop_front());
    endfunction

    // Offer one byte, hold it until the transaction completes, then predict
    task automatic send_byte(input logic [7:0] rx, input logic typed, input t_res want);
        if (!calm && $urandom_range(99) < 26) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_rx_byte <= rx;
        do @(posedge i_clk); while (!o_ready);
        n_rx++;
        deframe_byte(rx);
        if (typed) pending_res.push_back(want);
        else foreach (frame_res[k]) pending_res.push_back(frame_res[k]);
    endtask

    task automatic send_burst();
        foreach (burst_q[k]) send_byte(burst_q[k], 1'b0, NO_RES);
        burst_q.delete();
    endtask

    function automatic logic [7:0] sum_from(input int unsigned first);
        logic [7:0] sum;
        sum = 8'h00;
        for (int i = first; i < burst_q.size(); i++) sum = sum + burst_q[i];
        return sum;
    endfunction

    function automatic void add_frame(input logic [1:0] prio, input logic [7:0] addr,
                                      input logic rtr, input int unsigned len);
        int unsigned first;
        first = burst_q.size();
        burst_q.push_back(START_BYTE);
        burst_q.push_back(PRIO_TAG | {6'd0, prio});
        burst_q.push_back(addr);
        burst_q.push_back({1'b0, rtr, 2'b00, 4'(len)});
        repeat (len) burst_q.push_back(8'($urandom_range(255)));
        burst_q.push_back(8'h00 - sum_from(first));
        burst_q.push_back(END_BYTE);
    endfunction

    // Outer header that swallows a good inner frame, then fails its own checksum
    function automatic void add_nested();
        int unsigned first;
        int unsigned outer_len;
        int unsigned inner_len;
        first     = burst_q.size();
        outer_len = $urandom_range(MAX_DATA, HDR_TRL);
        inner_len = $urandom_range(outer_len - HDR_TRL, 0);
        burst_q.push_back(START_BYTE);
        burst_q.push_back(PRIO_TAG | 8'($urandom_range(3)));
        burst_q.push_back(8'($urandom_range(255)));
        burst_q.push_back({1'b0, 1'($urandom_range(1)), 2'b00, 4'(outer_len)});
        add_frame(2'($urandom_range(3)), 8'($urandom_range(255)), 1'($urandom_range(1)),
                  inner_len);
        repeat (outer_len - HDR_TRL - inner_len) burst_q.push_back(8'($urandom_range(255)));
        burst_q.push_back(8'h01 - sum_from(first));
        burst_q.push_back(END_BYTE);
    endfunction

    function automatic int unsigned pick_len();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 10) return MAX_DATA;
        if (r < 55) return $urandom_range(3);
        return $urandom_range(MAX_DATA);
    endfunction

    // Move predicted results to the checker at the sampling edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_res.size() == 0) begin
                report_mismatch("result with no frame pending");
            end else begin
                want_res = pending_res.pop_front();
                check_field("priority", 8'(o_priority_res), 8'(want_res.prio));
                check_field("address", o_address, want_res.addr);
                check_field("remote_request", 8'(o_remote_request), 8'(want_res.rtr));
                check_field("data_length", 8'(o_data_length), 8'(want_res.len));
                check_field("has_data", 8'(o_has_data), 8'(want_res.has_data));
                check_field("data_byte", o_data_byte, want_res.data);
                check_field("byte_index", 8'(o_byte_index), 8'(want_res.idx));
                check_field("last", 8'(o_last), 8'(want_res.last));
            end
        end
    end

    // Drive receiver ready: random stalls, one long hold-off counted here
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (hold_go && hold_left < HOLD_CYCLES) begin
            i_ready   <= 1'b0;
            hold_left <= hold_left + 1;
        end else begin
            i_ready <= calm || ($urandom_range(99) >= 26);
        end
    end

    // Stimulus
    initial begin
        int frm;
        int kind;
        int keep;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[r]) send_byte(dir_rows[r].rx, dir_rows[r].typed, dir_rows[r].want);

        frm = 0;
        while (n_rx < 270) begin
            calm = (n_rx >= 130 && n_rx < 200);
            // Stall the output long enough for the frame queue to back up
            if (frm == 8) hold_go <= 1'b1;
            // Pause the input until every pending frame result has drained
            if (frm == 14) begin
                i_valid <= 1'b0;
                wait (pending_res.size() == 0);
                @(posedge i_clk);
            end
            kind = $urandom_range(99);
            if (kind < 60) begin
                add_frame(2'($urandom_range(3)), 8'($urandom_range(255)),
                          1'($urandom_range(1)), pick_len());
            end else if (kind < 72) begin
                add_frame(2'($urandom_range(3)), 8'($urandom_range(255)),
                          1'($urandom_range(1)), pick_len());
                burst_q[$urandom_range(burst_q.size() - 1)] = 8'($urandom_range(255));
            end else if (kind < 82) begin
                repeat ($urandom_range(3, 1)) burst_q.push_back(8'($urandom_range(255)));
            end else if (kind < 90) begin
                add_nested();
            end else begin
                add_frame(2'($urandom_range(3)), 8'($urandom_range(255)),
                          1'($urandom_range(1)), pick_len());
                keep = $urandom_range(burst_q.size() - 1, 1);
                while (burst_q.size() > keep) void'(burst_q.pop_back());
            end
            send_burst();
            frm++;
        end
        calm = 1'b0;
        i_valid <= 1'b0;

        wait (pending_res.size() == 0);
        repeat (80) @(posedge i_clk);
        if (n_err == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

    // Bound the run
    initial begin
        #5_000_000;
        $display("tb failed");
        $finish;
    end

endmodule
